>>> rtl/tens_pkg.sv
package tens_pkg;

    // Field widths
    localparam int X_W      = 20;
    localparam int CNT_IN_W = 6;
    localparam int SUM_W    = 48;
    localparam int STAT_W   = 2;
    localparam int MAG_W    = 48;
    localparam int PROD_W   = 64;
    localparam int ACC_W    = 64;
    localparam int RMAG_W   = 52;
    localparam int BIT_W    = 6;
    localparam int STEP_W   = 4;
    localparam int SHR_W    = 16;
    localparam int RND_W    = 12;
    localparam int HALF_W   = 24;

    localparam int TENS_MAX_TERMS = 32;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVF  = 2'd2;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_MLO,
        OP_MHI,
        OP_DINIT,
        OP_DSTEP,
        OP_TERM,
        OP_ROUND,
        OP_SAT
    } op_t;

    // Jump conditions: jump to target when true, else advance
    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_NOACC,
        C_ZERO,
        C_LAST,
        C_BITS,
        C_BUSY
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic zero;
        logic last;
        logic bits_left;
        logic busy;
    } tens_flags_t;

    // Program steps
    localparam logic [STEP_W-1:0] S_WAIT  = 4'd0;
    localparam logic [STEP_W-1:0] S_CHKZ  = 4'd1;
    localparam logic [STEP_W-1:0] S_TEST  = 4'd2;
    localparam logic [STEP_W-1:0] S_MLO   = 4'd3;
    localparam logic [STEP_W-1:0] S_MHI   = 4'd4;
    localparam logic [STEP_W-1:0] S_DINIT = 4'd5;
    localparam logic [STEP_W-1:0] S_DSTEP = 4'd6;
    localparam logic [STEP_W-1:0] S_TERM  = 4'd7;
    localparam logic [STEP_W-1:0] S_ROUND = 4'd8;
    localparam logic [STEP_W-1:0] S_HOLD  = 4'd9;
    localparam logic [STEP_W-1:0] S_SAT   = 4'd10;

    // Microcode ROM
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        begin
            unique case (step)
                S_WAIT:  w = '{OP_WAIT,  C_NOACC, S_WAIT};
                S_CHKZ:  w = '{OP_NOP,   C_ZERO,  S_HOLD};
                S_TEST:  w = '{OP_NOP,   C_LAST,  S_ROUND};
                S_MLO:   w = '{OP_MLO,   C_NEXT,  S_WAIT};
                S_MHI:   w = '{OP_MHI,   C_NEXT,  S_WAIT};
                S_DINIT: w = '{OP_DINIT, C_NEXT,  S_WAIT};
                S_DSTEP: w = '{OP_DSTEP, C_BITS,  S_DSTEP};
                S_TERM:  w = '{OP_TERM,  C_JUMP,  S_TEST};
                S_ROUND: w = '{OP_ROUND, C_NEXT,  S_WAIT};
                S_HOLD:  w = '{OP_NOP,   C_BUSY,  S_HOLD};
                S_SAT:   w = '{OP_SAT,   C_JUMP,  S_WAIT};
                default: w = '{OP_NOP,   C_JUMP,  S_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

>>> rtl/tens_seq.sv
module tens_seq
    import tens_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tens_flags_t flags,
    output ctrl_t       ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              take;

    // Fetch the control word of the current step
    assign ctrl = ucode(step_reg);

    // Evaluate the jump condition
    always_comb
    begin
        unique case (ctrl.cond)
            C_NEXT:  take = 1'b0;
            C_JUMP:  take = 1'b1;
            C_NOACC: take = !flags.accept;
            C_ZERO:  take = flags.zero;
            C_LAST:  take = flags.last;
            C_BITS:  take = flags.bits_left;
            C_BUSY:  take = flags.busy;
            default: take = 1'b1;
        endcase
        step_next = take ? ctrl.target : step_reg + 1'b1;
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

>>> rtl/taylor_exp_neg_series.sv
// Before it writes a result, the sequencer holds until the previous result has been taken.
// Each term costs two half-width multiply steps and a 48-bit bit-serial divide by the index.
// Throughput: one item at a time; a new item is taken only when the previous one is finished.
// Reset (rst_n, asynchronous, active low) returns the sequencer to its wait step and empties
// the output register; arithmetic registers are not reset.
module taylor_exp_neg_series
    import tens_pkg::*;
#(
    parameter int MAX_TERMS = TENS_MAX_TERMS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [19:0] x_value, [25:20] term_count, [31:26] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [47:0] sum, [49:48] status, [55:50] zero
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam logic [6:0] MAX_T7 = 7'(MAX_TERMS);
    localparam logic [RMAG_W-1:0] POS_LIM = RMAG_W'((64'd1 << (SUM_W - 1)) - 64'd1);
    localparam logic [RMAG_W-1:0] NEG_LIM = RMAG_W'(64'd1 << (SUM_W - 1));
    localparam logic [ACC_W-1:0]  ONE_Q32 = ACC_W'(64'd1 << 32);
    localparam logic [ACC_W-1:0]  RND_HALF = ACC_W'(64'd1 << (RND_W - 1));

    ctrl_t       ctrl;
    tens_flags_t flags;
    logic        accept;

    logic [X_W-1:0]    xmag_reg, xmag_next;
    logic              xpos_reg, xpos_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              zero_reg, zero_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MAG_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              tneg_reg, tneg_next;
    logic [RMAG_W-1:0] rmag_reg, rmag_next;
    logic              sneg_reg, sneg_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic              out_valid_reg, out_valid_next;

    logic [X_W-1:0]      x_raw;
    logic [6:0]          cnt_ext;
    logic [2*HALF_W-4:0] mul_lo;
    logic [2*HALF_W-4:0] mul_hi;
    logic [CNT_W:0]      div_shift;
    logic [CNT_W:0]      div_diff;
    logic                div_ge;
    logic                tneg_new;
    logic [ACC_W-1:0]    amag;
    logic [ACC_W-1:0]    rsum;

    tens_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign s_tready = (ctrl.op == OP_WAIT);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, stat_reg, sum_reg};

    // Status flags for the sequencer
    assign flags.accept    = accept;
    assign flags.zero      = zero_reg;
    assign flags.last      = (idx_reg >= count_reg);
    assign flags.bits_left = (bit_reg != '0);
    assign flags.busy      = out_valid_reg && !m_tready;

    // Input decode
    assign x_raw   = s_tdata[X_W-1:0];
    assign cnt_ext = {1'b0, s_tdata[X_W+CNT_IN_W-1:X_W]};

    // Half-width products of the term magnitude and |x|
    assign mul_lo = mag_reg[HALF_W-1:0] * xmag_reg;
    assign mul_hi = mag_reg[MAG_W-1:HALF_W] * xmag_reg;

    // One restoring divide step by the term index
    assign div_shift = {rem_reg, quo_reg[MAG_W-1]};
    assign div_ge    = (div_shift >= {1'b0, idx_reg});
    assign div_diff  = div_shift - {1'b0, idx_reg};

    assign tneg_new = tneg_reg ^ xpos_reg;
    assign amag     = acc_reg[ACC_W-1] ? (ACC_W'(0) - acc_reg) : acc_reg;
    assign rsum     = amag + RND_HALF;

    // Datapath operations selected by the control word
    always_comb
    begin
        xmag_next  = xmag_reg;
        xpos_next  = xpos_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        zero_next  = zero_reg;
        mag_next   = mag_reg;
        prod_next  = prod_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        acc_next   = acc_reg;
        tneg_next  = tneg_reg;
        rmag_next  = rmag_reg;
        sneg_next  = sneg_reg;
        sum_next   = sum_reg;
        stat_next  = stat_reg;

        unique case (ctrl.op)
            OP_WAIT:
            begin
                // Load the argument and start with term 1.0
                if (accept)
                begin
                    xmag_next = x_raw[X_W-1] ? (X_W'(0) - x_raw) : x_raw;
                    xpos_next = !x_raw[X_W-1] && (x_raw != '0);
                    zero_next = (cnt_ext == '0);
                    if (cnt_ext > MAX_T7)
                        count_next = MAX_T7[CNT_W-1:0];
                    else
                        count_next = cnt_ext[CNT_W-1:0];
                    idx_next  = CNT_W'(1);
                    mag_next  = MAG_W'(ONE_Q32);
                    acc_next  = ONE_Q32;
                    tneg_next = 1'b0;
                end
            end
            OP_MLO:
            begin
                prod_next = PROD_W'(mul_lo);
            end
            OP_MHI:
            begin
                prod_next = prod_reg + {mul_hi[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}};
            end
            OP_DINIT:
            begin
                quo_next = prod_reg[PROD_W-1:SHR_W];
                rem_next = '0;
                bit_next = BIT_W'(MAG_W - 1);
            end
            OP_DSTEP:
            begin
                quo_next = {quo_reg[MAG_W-2:0], div_ge};
                rem_next = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
                bit_next = bit_reg - 1'b1;
            end
            OP_TERM:
            begin
                // Accumulate the new term with its alternating sign
                mag_next  = quo_reg;
                tneg_next = tneg_new;
                if (tneg_new)
                    acc_next = acc_reg - ACC_W'(quo_reg);
                else
                    acc_next = acc_reg + ACC_W'(quo_reg);
                idx_next  = idx_reg + 1'b1;
            end
            OP_ROUND:
            begin
                // Round the magnitude to Q.20, ties away from zero
                sneg_next = acc_reg[ACC_W-1];
                rmag_next = rsum[ACC_W-1:RND_W];
            end
            OP_SAT:
            begin
                if (zero_reg)
                begin
                    sum_next  = '0;
                    stat_next = ST_ZERO;
                end
                else if (sneg_reg)
                begin
                    if (rmag_reg > NEG_LIM)
                    begin
                        sum_next  = NEG_LIM[SUM_W-1:0];
                        stat_next = ST_OVF;
                    end
                    else
                    begin
                        sum_next  = SUM_W'(RMAG_W'(0) - rmag_reg);
                        stat_next = ST_OK;
                    end
                end
                else
                begin
                    if (rmag_reg > POS_LIM)
                    begin
                        sum_next  = POS_LIM[SUM_W-1:0];
                        stat_next = ST_OVF;
                    end
                    else
                    begin
                        sum_next  = rmag_reg[SUM_W-1:0];
                        stat_next = ST_OK;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output valid: set on a finished result, drop after the transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        if (ctrl.op == OP_SAT)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Arithmetic registers
    always_ff @(posedge clk)
    begin
        xmag_reg  <= xmag_next;
        xpos_reg  <= xpos_next;
        count_reg <= count_next;
        idx_reg   <= idx_next;
        zero_reg  <= zero_next;
        mag_reg   <= mag_next;
        prod_reg  <= prod_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
        acc_reg   <= acc_next;
        tneg_reg  <= tneg_next;
        rmag_reg  <= rmag_next;
        sneg_reg  <= sneg_next;
        sum_reg   <= sum_next;
        stat_reg  <= stat_next;
    end

endmodule

>>> bench/tens_series_checker.sv
`timescale 1ns / 100ps

// Watch both stream channels, predict each series sum, compare field by field.
module tens_series_checker
    import tens_pkg::*;
#(
    parameter int MAX_TERMS = TENS_MAX_TERMS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [19:0] x_value, [25:20] term_count, [31:26] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // [47:0] sum, [49:48] status, [55:50] zero
    output int          fail_count,
    output int          sums_waiting,
    output int          sums_checked
);

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [STAT_W-1:0] status;
    } series_t;

    series_t sum_q[$];

    // Truncated series of exp(-x): sign plus Q.32 magnitude per term, Q.32 accumulator
    function automatic series_t series_exp_neg(input logic [X_W-1:0] x_raw,
                                               input logic [CNT_IN_W-1:0] n_in);
        series_t     r;
        logic [63:0] xmag;
        logic [63:0] mag;
        logic [63:0] acc;
        logic [63:0] amag;
        logic [63:0] rmag;
        logic        xneg;
        logic        xpos;
        logic        tneg;
        logic        sneg;
        int unsigned n;
        begin
            xneg = x_raw[X_W-1];
            xmag = xneg ? {44'd0, (20'd0 - x_raw)} : {44'd0, x_raw};
            xpos = !xneg && (xmag != 64'd0);
            r.status = ST_OK;
            // Empty series is an error with a zero sum
            if (n_in == '0)
            begin
                r.sum    = '0;
                r.status = ST_ZERO;
                return r;
            end
            n    = (n_in > MAX_TERMS) ? MAX_TERMS : n_in;
            mag  = 64'd1 << 32;
            tneg = 1'b0;
            acc  = mag;
            for (int unsigned i = 1; i < n; i++)
            begin
                mag = ((mag * xmag) >> 16) / i;
                if (mag > (64'd1 << 48))
                    mag = 64'd1 << 48;
                if (xpos)
                    tneg = !tneg;
                acc = tneg ? (acc - mag) : (acc + mag);
            end
            // Round the magnitude to Q.20, ties away from zero, then clamp
            sneg = acc[63];
            amag = sneg ? (64'd0 - acc) : acc;
            rmag = (amag + 64'd2048) >> 12;
            if (sneg)
            begin
                if (rmag > (64'd1 << 47))
                begin
                    rmag     = 64'd1 << 47;
                    r.status = ST_OVF;
                end
                r.sum = 48'(64'd0 - rmag);
            end
            else
            begin
                if (rmag > ((64'd1 << 47) - 64'd1))
                begin
                    rmag     = (64'd1 << 47) - 64'd1;
                    r.status = ST_OVF;
                end
                r.sum = rmag[SUM_W-1:0];
            end
            return r;
        end
    endfunction

    // Retire the oldest expectation before queuing a new one in the same cycle
    always @(posedge clk)
    begin
        series_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (sum_q.size() == 0)
                begin
                    $error("unexpected result transfer: sum %h status %0d",
                           m_tdata[47:0], m_tdata[49:48]);
                    fail_count++;
                end
                else
                begin
                    want = sum_q.pop_front();
                    sums_checked++;
                    if (m_tdata[47:0] !== want.sum)
                    begin
                        $error("field sum: expected %0d, actual %0d",
                               $signed(want.sum), $signed(m_tdata[47:0]));
                        fail_count++;
                    end
                    if (m_tdata[49:48] !== want.status)
                    begin
                        $error("field status: expected %0d, actual %0d",
                               want.status, m_tdata[49:48]);
                        fail_count++;
                    end
                    if (m_tdata[55:50] !== 6'd0)
                    begin
                        $error("field pad: expected 0, actual %h", m_tdata[55:50]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                sum_q.push_back(series_exp_neg(s_tdata[19:0], s_tdata[25:20]));
            sums_waiting = sum_q.size();
        end
    end

endmodule

>>> bench/tb_taylor_exp_neg_series.sv
`timescale 1ns / 100ps

module tb_taylor_exp_neg_series;
    import tens_pkg::*;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [19:0] x_value, [25:20] term_count, [31:26] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // [47:0] sum, [49:48] status, [55:50] zero

    int fail_count;
    int sums_waiting;
    int sums_checked;
    int items_sent  = 0;
    int empty_sent  = 0;
    int capped_sent = 0;
    bit gaps_on     = 1'b1;
    bit stalls_on   = 1'b1;

    taylor_exp_neg_series u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tens_series_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .sums_waiting (sums_waiting),
        .sums_checked (sums_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Guard against a hung handshake
    initial
    begin
        #25_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Stall the result side in random bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Offer one item, optionally after an idle burst, and hold it until the transfer
    task automatic send_item(input logic [X_W-1:0] x, input logic [CNT_IN_W-1:0] n);
        logic took;
        begin
            if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {6'd0, n, x};
            took = 1'b0;
            while (!took)
            begin
                @(negedge clk);
                took = s_tready;
                @(posedge clk);
            end
            items_sent++;
            if (n == '0)
                empty_sent++;
            if (n > TENS_MAX_TERMS)
                capped_sent++;
        end
    endtask

    initial
    begin
        logic [X_W-1:0]      x;
        logic [CNT_IN_W-1:0] n;
        int                  pick;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty series, zero argument, unit terms, range extremes, capped counts
        send_item(20'd0, 6'd0);
        send_item(20'h7FFFF, 6'd0);
        send_item(20'h80000, 6'd0);
        send_item(20'd0, 6'd1);
        send_item(20'd0, 6'd32);
        send_item(20'd65536, 6'd1);
        send_item(20'd65536, 6'd2);
        send_item(20'd65536, 6'd32);
        send_item(-20'sd65536, 6'd32);
        send_item(20'h7FFFF, 6'd32);
        send_item(20'h80000, 6'd32);
        send_item(20'h80000, 6'd63);
        send_item(20'h7FFFF, 6'd63);
        send_item(20'd1, 6'd33);
        send_item(20'hFFFFF, 6'd32);
        send_item(20'hFFFFF, 6'd2);
        send_item(20'd32768, 6'd10);
        send_item(20'd131072, 6'd20);
        send_item(-20'sd131072, 6'd5);
        send_item(20'd12345, 6'd48);

        // Random: mostly short series, some long ones, idling switched per stretch
        for (int k = 0; k < 350; k++)
        begin
            if (k % 40 == 0)
            begin
                gaps_on   = $urandom_range(0, 2) != 0;
                stalls_on = $urandom_range(0, 2) != 0;
            end
            if (k >= 290)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7)
                n = CNT_IN_W'($urandom_range(0, 10));
            else if (pick < 9)
                n = CNT_IN_W'($urandom_range(11, 32));
            else
                n = CNT_IN_W'($urandom_range(33, 63));
            pick = $urandom_range(0, 7);
            if (pick < 4)
                x = X_W'($urandom_range(0, 20'hFFFFF));
            else if (pick < 6)
                x = X_W'($urandom_range(0, 262144) - 131072);
            else if (pick == 6)
                x = X_W'($urandom_range(0, 4) - 2);
            else
                x = ($urandom_range(0, 1) != 0) ? 20'h80000 : 20'h7FFFF;
            send_item(x, n);
        end
        s_tvalid <= 1'b0;

        // Drain outstanding sums, then wait for stray results
        do
            @(negedge clk);
        while (sums_waiting != 0);
        repeat (60) @(posedge clk);

        $display("Sent %0d items (%0d empty series, %0d with capped term count), %0d sums checked",
                 items_sent, empty_sent, capped_sent, sums_checked);
        $display("Arguments spanned the full signed Q4.16 range, term counts 0 to 63");
        if (fail_count == 0 && sums_waiting == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
